FILE: design/otsu_pkg.sv
// otsu_pkg: widths, state codes and control structs for the otsu binariser
// used by otsu_hist, otsu_mul and otsu_threshold_binarize; no dependencies
package otsu_pkg;

    localparam int LW        = 8;                 // gray level bits
    localparam int LEVELS    = 1 << LW;           // histogram bins
    localparam int CW        = 22;                // bin and pixel count bits
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam int SW        = CW + LW;           // weighted sums
    localparam int PQW       = CW + SW;           // sb*T and S*fg
    localparam int D2W       = 2 * PQW;           // squared difference
    localparam int DENW      = 2 * CW;            // fg*bg
    localparam int MAW       = D2W;               // multiplicand width
    localparam int MBW       = PQW;               // multiplier width
    localparam int PW        = MAW + MBW;         // product width

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_ACC_WR  = 10'b00_0000_0010,
        S_SUM_RD  = 10'b00_0000_0100,
        S_SUM_ADD = 10'b00_0000_1000,
        S_LV_RD   = 10'b00_0001_0000,
        S_LV_ADD  = 10'b00_0010_0000,
        S_LV_CHK  = 10'b00_0100_0000,
        S_MUL     = 10'b00_1000_0000,
        S_EMIT    = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        M_P   = 3'd0,
        M_Q   = 3'd1,
        M_D   = 3'd2,
        M_DEN = 3'd3,
        M_L   = 3'd4,
        M_R   = 3'd5
    } mstep_t;

    localparam logic OP_ACC = 1'b0;
    localparam logic OP_BIN = 1'b1;
    localparam logic KIND_THR = 1'b0;
    localparam logic KIND_PIX = 1'b1;

    typedef struct packed {
        logic          rd_en;
        logic [LW-1:0] rd_addr;
        logic          wr_en;
        logic [LW-1:0] wr_addr;
        logic [CW-1:0] wr_data;
        logic          clr;
    } hist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

FILE: design/otsu_hist.sv
// otsu_hist: histogram memory with per-bin valid bits, registered read
// depends on otsu_pkg
module otsu_hist (
    input  logic                      clk,
    input  logic                      rst_n,
    input  otsu_pkg::hist_ctrl_t      ctrl,
    output logic [otsu_pkg::CW-1:0]   rd_data
);

    logic [otsu_pkg::CW-1:0]     mem [otsu_pkg::LEVELS];
    logic [otsu_pkg::LEVELS-1:0] valid_reg;
    logic [otsu_pkg::CW-1:0]     rd_data_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg  <= mem[ctrl.rd_addr];
            rd_valid_reg <= valid_reg[ctrl.rd_addr];
        end
    end

    // a bin not written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[ctrl.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: design/otsu_mul.sv
// otsu_mul: shared shift-add multiplier, one partial product per cycle
// depends on otsu_pkg
module otsu_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [otsu_pkg::MAW-1:0]  a,
    input  logic [otsu_pkg::MBW-1:0]  b,
    output otsu_pkg::mul_stat_t       stat,
    output logic [otsu_pkg::PW-1:0]   prod
);

    logic [otsu_pkg::PW-1:0]  a_reg;
    logic [otsu_pkg::MBW-1:0] b_reg;
    logic [otsu_pkg::PW-1:0]  acc_reg;
    logic                     busy_reg;

    // finishes as soon as no multiplier bits remain
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (b_reg == '0);
    assign prod      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (stat.done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= otsu_pkg::PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

FILE: design/otsu_threshold_binarize.sv
// otsu_threshold_binarize: two-pass otsu binariser, top level and sequencer
// depends on otsu_pkg, otsu_hist, otsu_mul
//
// input stream: tdata[7:0] pixel, tlast ends the accumulate pass,
//   tuser 0 accumulates the pixel, 1 binarises it
// output stream: tuser 0 threshold report, 1 binarised pixel;
//   tdata[7:0] threshold, tdata[15:8] out pixel (0 in a report)
// cfg_wr_en / cfg_wr_data write max_level (white value, top scanned level)
// an accumulate item is a histogram read, then a write back
// a binarise item passes through S_OUT, waiting there for the output register
// a last accumulate item starts the scan: a read and an add per level up
//   to max_level for the sums, then per level a read, an add and a check,
//   and for a level with no empty class six products through the shared
//   multiplier, which runs until no bits of its second operand remain
// the multiplier computes all six products of a level and sets the scan length
// reset clears the histogram valid bits at once, so no clearing pass;
//   threshold resets to 0 and max_level to 255
// a stalled receiver holds the result in the output register; one more
//   result waits in the sequencer, and the block is not ready until it moves
module otsu_threshold_binarize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel
    input  logic        s_axis_tlast,   // last
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // threshold, out_pixel
    output logic        m_axis_tuser,   // result_kind
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data     // max_level
);

    localparam int LW   = otsu_pkg::LW;
    localparam int CW   = otsu_pkg::CW;
    localparam int SW   = otsu_pkg::SW;
    localparam int PQW  = otsu_pkg::PQW;
    localparam int D2W  = otsu_pkg::D2W;
    localparam int DENW = otsu_pkg::DENW;
    localparam int PW   = otsu_pkg::PW;

    // control state
    otsu_pkg::state_t state_reg, state_next;
    logic [CW-1:0] pixel_total_reg, pixel_total_next;
    logic [LW-1:0] chosen_reg, chosen_next;
    logic [LW-1:0] max_level_reg;
    logic          out_valid_reg, out_valid_next;

    // payload
    otsu_pkg::mstep_t mstep_reg, mstep_next;
    logic [LW-1:0]   px_reg, px_next;
    logic            last_reg, last_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   total_reg, total_next;
    logic [SW-1:0]   wsum_reg, wsum_next;
    logic [CW-1:0]   fg_reg, fg_next;
    logic [SW-1:0]   sb_reg, sb_next;
    logic [PQW-1:0]  p_reg, p_next;
    logic [D2W-1:0]  d2_reg, d2_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [PW-1:0]   l_reg, l_next;
    logic [D2W-1:0]  best_num_reg, best_num_next;
    logic [DENW-1:0] best_den_reg, best_den_next;
    logic [LW-1:0]   pick_reg, pick_next;
    logic            pend_kind_reg, pend_kind_next;
    logic [LW-1:0]   pend_thr_reg, pend_thr_next;
    logic [LW-1:0]   pend_pix_reg, pend_pix_next;
    logic            out_kind_reg, out_kind_next;
    logic [LW-1:0]   out_thr_reg, out_thr_next;
    logic [LW-1:0]   out_pix_reg, out_pix_next;

    otsu_pkg::hist_ctrl_t hist_ctrl;
    logic [CW-1:0]        hist_data;
    logic                 mul_start;
    logic [otsu_pkg::MAW-1:0] mul_a;
    logic [otsu_pkg::MBW-1:0] mul_b;
    otsu_pkg::mul_stat_t  mul_stat;
    logic [PW-1:0]        mul_prod;

    logic [LW-1:0]  in_px;
    logic [CW-1:0]  bg;
    logic [SW-1:0]  wprod;
    logic [PQW-1:0] q_val;
    logic [PQW-1:0] d_val;
    logic           out_free;

    otsu_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hist_ctrl),
        .rd_data (hist_data)
    );

    otsu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    // pixel clamped to the top scanned level
    assign in_px = (s_axis_tdata > max_level_reg) ? max_level_reg : s_axis_tdata;
    assign bg    = total_reg - fg_reg;
    // level times bin count, feeds both running sums
    assign wprod = SW'(idx_reg) * SW'(hist_data);
    assign q_val = mul_prod[PQW-1:0];
    assign d_val = (p_reg >= q_val) ? (p_reg - q_val) : (q_val - p_reg);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == otsu_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_pix_reg, out_thr_reg};

    always_comb
    begin
        state_next       = state_reg;
        pixel_total_next = pixel_total_reg;
        chosen_next      = chosen_reg;
        out_valid_next   = out_valid_reg;
        mstep_next       = mstep_reg;
        px_next          = px_reg;
        last_next        = last_reg;
        idx_next         = idx_reg;
        total_next       = total_reg;
        wsum_next        = wsum_reg;
        fg_next          = fg_reg;
        sb_next          = sb_reg;
        p_next           = p_reg;
        d2_next          = d2_reg;
        den_next         = den_reg;
        l_next           = l_reg;
        best_num_next    = best_num_reg;
        best_den_next    = best_den_reg;
        pick_next        = pick_reg;
        pend_kind_next   = pend_kind_reg;
        pend_thr_next    = pend_thr_reg;
        pend_pix_next    = pend_pix_reg;
        out_kind_next    = out_kind_reg;
        out_thr_next     = out_thr_reg;
        out_pix_next     = out_pix_reg;
        hist_ctrl        = '0;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            otsu_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    px_next   = in_px;
                    last_next = s_axis_tlast;
                    if (s_axis_tuser == otsu_pkg::OP_ACC)
                    begin
                        if (pixel_total_reg < otsu_pkg::COUNT_MAX)
                        begin
                            hist_ctrl.rd_en   = 1'b1;
                            hist_ctrl.rd_addr = in_px;
                            state_next        = otsu_pkg::S_ACC_WR;
                        end
                        else if (s_axis_tlast)
                        begin
                            // count saturated: straight to the scan
                            idx_next   = '0;
                            total_next = '0;
                            wsum_next  = '0;
                            state_next = otsu_pkg::S_SUM_RD;
                        end
                    end
                    else
                    begin
                        pend_kind_next = otsu_pkg::KIND_PIX;
                        pend_thr_next  = chosen_reg;
                        pend_pix_next  = (in_px < chosen_reg) ? '0 : max_level_reg;
                        state_next     = otsu_pkg::S_OUT;
                    end
                end
            end

            otsu_pkg::S_ACC_WR:
            begin
                hist_ctrl.wr_en   = 1'b1;
                hist_ctrl.wr_addr = px_reg;
                hist_ctrl.wr_data = hist_data + CW'(1);
                pixel_total_next  = pixel_total_reg + CW'(1);
                if (last_reg)
                begin
                    idx_next   = '0;
                    total_next = '0;
                    wsum_next  = '0;
                    state_next = otsu_pkg::S_SUM_RD;
                end
                else
                begin
                    state_next = otsu_pkg::S_IDLE;
                end
            end

            // first sweep: total count and weighted sum up to max_level
            otsu_pkg::S_SUM_RD:
            begin
                hist_ctrl.rd_en   = 1'b1;
                hist_ctrl.rd_addr = idx_reg;
                state_next        = otsu_pkg::S_SUM_ADD;
            end

            otsu_pkg::S_SUM_ADD:
            begin
                total_next = total_reg + hist_data;
                wsum_next  = wsum_reg + wprod;
                if (idx_reg == max_level_reg)
                begin
                    idx_next      = '0;
                    fg_next       = '0;
                    sb_next       = '0;
                    best_num_next = '0;
                    best_den_next = DENW'(1);
                    pick_next     = '0;
                    state_next    = otsu_pkg::S_LV_RD;
                end
                else
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = otsu_pkg::S_SUM_RD;
                end
            end

            // second sweep: one level at a time, through the multiplier unless a class is empty
            otsu_pkg::S_LV_RD:
            begin
                hist_ctrl.rd_en   = 1'b1;
                hist_ctrl.rd_addr = idx_reg;
                state_next        = otsu_pkg::S_LV_ADD;
            end

            otsu_pkg::S_LV_ADD:
            begin
                fg_next    = fg_reg + hist_data;
                sb_next    = sb_reg + wprod;
                state_next = otsu_pkg::S_LV_CHK;
            end

            otsu_pkg::S_LV_CHK:
            begin
                if ((fg_reg == '0) || (bg == '0))
                begin
                    // empty class: level skipped
                    if (idx_reg == max_level_reg)
                    begin
                        state_next = otsu_pkg::S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LW'(1);
                        state_next = otsu_pkg::S_LV_RD;
                    end
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = otsu_pkg::MAW'(sb_reg);
                    mul_b      = otsu_pkg::MBW'(total_reg);
                    mstep_next = otsu_pkg::M_P;
                    state_next = otsu_pkg::S_MUL;
                end
            end

            otsu_pkg::S_MUL:
            begin
                if (mul_stat.done)
                begin
                    case (mstep_reg)
                        otsu_pkg::M_P:
                        begin
                            p_next     = mul_prod[PQW-1:0];
                            mul_start  = 1'b1;
                            mul_a      = otsu_pkg::MAW'(wsum_reg);
                            mul_b      = otsu_pkg::MBW'(fg_reg);
                            mstep_next = otsu_pkg::M_Q;
                        end
                        otsu_pkg::M_Q:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = otsu_pkg::MAW'(d_val);
                            mul_b      = otsu_pkg::MBW'(d_val);
                            mstep_next = otsu_pkg::M_D;
                        end
                        otsu_pkg::M_D:
                        begin
                            d2_next    = mul_prod[D2W-1:0];
                            mul_start  = 1'b1;
                            mul_a      = otsu_pkg::MAW'(fg_reg);
                            mul_b      = otsu_pkg::MBW'(bg);
                            mstep_next = otsu_pkg::M_DEN;
                        end
                        otsu_pkg::M_DEN:
                        begin
                            den_next   = mul_prod[DENW-1:0];
                            mul_start  = 1'b1;
                            mul_a      = d2_reg;
                            mul_b      = otsu_pkg::MBW'(best_den_reg);
                            mstep_next = otsu_pkg::M_L;
                        end
                        otsu_pkg::M_L:
                        begin
                            l_next     = mul_prod;
                            mul_start  = 1'b1;
                            mul_a      = best_num_reg;
                            mul_b      = otsu_pkg::MBW'(den_reg);
                            mstep_next = otsu_pkg::M_R;
                        end
                        default:
                        begin
                            // strictly greater keeps the first best level
                            if (l_reg > mul_prod)
                            begin
                                best_num_next = d2_reg;
                                best_den_next = den_reg;
                                pick_next     = idx_reg;
                            end
                            if (idx_reg == max_level_reg)
                            begin
                                state_next = otsu_pkg::S_EMIT;
                            end
                            else
                            begin
                                idx_next   = idx_reg + LW'(1);
                                state_next = otsu_pkg::S_LV_RD;
                            end
                        end
                    endcase
                end
            end

            otsu_pkg::S_EMIT:
            begin
                chosen_next      = pick_reg;
                hist_ctrl.clr    = 1'b1;
                pixel_total_next = '0;
                pend_kind_next   = otsu_pkg::KIND_THR;
                pend_thr_next    = pick_reg;
                pend_pix_next    = '0;
                state_next       = otsu_pkg::S_OUT;
            end

            otsu_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_thr_next   = pend_thr_reg;
                    out_pix_next   = pend_pix_reg;
                    state_next     = otsu_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = otsu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= otsu_pkg::S_IDLE;
            pixel_total_reg <= '0;
            chosen_reg      <= '0;
            max_level_reg   <= 8'd255;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_total_reg <= pixel_total_next;
            chosen_reg      <= chosen_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_level_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mstep_reg     <= mstep_next;
        px_reg        <= px_next;
        last_reg      <= last_next;
        idx_reg       <= idx_next;
        total_reg     <= total_next;
        wsum_reg      <= wsum_next;
        fg_reg        <= fg_next;
        sb_reg        <= sb_next;
        p_reg         <= p_next;
        d2_reg        <= d2_next;
        den_reg       <= den_next;
        l_reg         <= l_next;
        best_num_reg  <= best_num_next;
        best_den_reg  <= best_den_next;
        pick_reg      <= pick_next;
        pend_kind_reg <= pend_kind_next;
        pend_thr_reg  <= pend_thr_next;
        pend_pix_reg  <= pend_pix_next;
        out_kind_reg  <= out_kind_next;
        out_thr_reg   <= out_thr_next;
        out_pix_reg   <= out_pix_next;
    end

    // multiplier is only restarted once the previous product is ready
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> (!mul_stat.busy || mul_stat.done))
        else $error("multiplier restarted while busy");

    // best ratio denominator never zero while levels are compared
    a_best_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == otsu_pkg::S_MUL) |-> (best_den_reg != '0))
        else $error("zero best denominator");

    // a finished scan leaves an empty pass behind
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == otsu_pkg::S_EMIT) |=> (pixel_total_reg == '0))
        else $error("pixel count not cleared after scan");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(m_axis_tdata)))
        else $error("output result lost");

endmodule
